### rtl/core/tbbq_pkg.sv
// ----------------------------------------------------------------------------
// tbbq_pkg
// Shared types, constants and helpers of the token budget batch queue.
// ----------------------------------------------------------------------------
package tbbq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int LEN_BITS    = 16;

  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W  = ID_BITS + LEN_BITS;
  localparam int STATUS_W = 3;

  localparam int LIMIT_W  = 9;
  localparam int SEQ_W    = 16;
  localparam int BUDGET_W = LIMIT_W + SEQ_W;
  localparam int CMP_W    = ((BUDGET_W > LEN_BITS) ? BUDGET_W : LEN_BITS) + 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1);
  localparam logic [SEQ_W-1:0]   SEQ_RST   = SEQ_W'(2048);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ID_BITS + 2 * CNT_W + 7) / 8) * 8;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_STARTED  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    MODE_ENQUEUE  = 1'b0,
    MODE_SCHEDULE = 1'b1
  } mode_e;

  typedef enum logic {
    REG_BATCH_LIMIT = 1'b0,
    REG_SEQ_LIMIT   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EVAL,
    BK_FLUSH
  } back_state_e;

  typedef struct packed {
    mode_e               mode;
    logic [ID_BITS-1:0]  id;
    logic [LEN_BITS-1:0] len;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [ID_BITS-1:0] id;
    logic               last;
    logic [CNT_W-1:0]   batch;
    logic [CNT_W-1:0]   waiting;
  } result_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PTR_W'(1);
    end
    return nxt;
  endfunction

endpackage

### rtl/core/token_budget_batch_queue.sv
// ----------------------------------------------------------------------------
// token_budget_batch_queue
// FIFO of waiting requests, scheduled into batches under a token budget.
//
//   port group  | dir | contents
//   ------------+-----+-------------------------------------------------------
//   s_axis_*    | in  | requests: tuser mode, tdata stream_id and input_length
//   m_axis_*    | out | results: tuser status, tlast last, tdata tag & counts
//   APB         | in  | batch limit at 0x0, sequence length factor at 0x4
//
// Enqueue: the request passes the command queue and its result is registered.
// Schedule: the command is taken, then each request examined passes a RAM
// read state and then a budget compare state; a batch that empties the queue
// spends a flush state on its final result. The single RAM read port sets this.
// No clearing pass after reset; the front keeps accepting while the
// two-entry command queue has room, so either side stalls on its own.
// ----------------------------------------------------------------------------
module token_budget_batch_queue import tbbq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // stream_id, input_length
  input  logic                 s_axis_tuser,  // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // stream_id_res, batch_count, waiting_count
  output logic [STATUS_W-1:0]  m_axis_tuser,  // status
  output logic                 m_axis_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  logic                cmd_push, cmdq_full, cmd_valid, cmd_pop;
  cmd_t                cmd_in, cmd_out;
  logic [BUDGET_W-1:0] budget;
  result_t             res;

  tbbq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cmdq_full_i  (cmdq_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .budget_o     (budget)
  );

  tbbq_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .full_o (cmdq_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .cmd_o  (cmd_out)
  );

  tbbq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .budget_i   (budget),
    .res_valid_o(m_axis_tvalid),
    .res_o      (res),
    .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = M_TDATA_W'({res.waiting, res.batch, res.id});
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

### rtl/core/tbbq_ram.sv
// ----------------------------------------------------------------------------
// tbbq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tbbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tbbq_front.sv
// ----------------------------------------------------------------------------
// tbbq_front
// Input side: takes requests, classifies them into commands, and holds the
// configuration registers together with the registered token budget.
// ----------------------------------------------------------------------------
module tbbq_front import tbbq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  input  logic                 cmdq_full_i,
  output logic                 cmd_push_o,
  output cmd_t                 cmd_o,
  output logic [BUDGET_W-1:0]  budget_o
);

  logic [LIMIT_W-1:0]  limit_q, limit_d;
  logic [SEQ_W-1:0]    seq_q, seq_d;
  logic [BUDGET_W-1:0] budget_q;
  logic                wr_en;
  cfg_reg_e            reg_sel;

  assign s_axis_tready = !cmdq_full_i;
  assign cmd_push_o    = s_axis_tvalid && !cmdq_full_i;

  always_comb begin
    cmd_o      = '0;
    cmd_o.mode = mode_e'(s_axis_tuser);
    cmd_o.id   = s_axis_tdata[ID_BITS-1:0];
    cmd_o.len  = s_axis_tdata[ID_BITS +: LEN_BITS];
  end

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    limit_d = limit_q;
    seq_d   = seq_q;
    if (wr_en) begin
      case (reg_sel)
        REG_BATCH_LIMIT: limit_d = pwdata[LIMIT_W-1:0];
        REG_SEQ_LIMIT:   seq_d   = pwdata[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BATCH_LIMIT: prdata = APB_DW'(limit_q);
      REG_SEQ_LIMIT:   prdata = APB_DW'(seq_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RST;
      seq_q    <= SEQ_RST;
      budget_q <= BUDGET_W'(LIMIT_RST) * BUDGET_W'(SEQ_RST);
    end else begin
      limit_q  <= limit_d;
      seq_q    <= seq_d;
      budget_q <= BUDGET_W'(limit_q) * BUDGET_W'(seq_q);
    end
  end

  assign budget_o = budget_q;

endmodule

### rtl/core/tbbq_cmdq.sv
// ----------------------------------------------------------------------------
// tbbq_cmdq
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
module tbbq_cmdq import tbbq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                  slot_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CMDQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + CMDQ_PTR_W'(1);
      end
    end
  end

endmodule

### rtl/core/tbbq_back.sv
// ----------------------------------------------------------------------------
// tbbq_back
// Back part: owns the request FIFO, runs enqueue and schedule commands and
// drives the result register.
// ----------------------------------------------------------------------------
module tbbq_back import tbbq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  input  logic [BUDGET_W-1:0] budget_i,
  output logic                res_valid_o,
  output result_t             res_o,
  input  logic                res_ready_i
);

  back_state_e         state_q, state_d;
  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d, count_dec;
  logic [BUDGET_W-1:0] total_q, total_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic                pend_valid_q, pend_valid_d;
  result_t             pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, out_d;

  logic                slot_free, emit, fit;
  result_t             emit_res;
  logic                ram_we, ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ID_BITS-1:0]  rd_id;
  logic [LEN_BITS-1:0] rd_len;
  logic [CMP_W-1:0]    sum;

  tbbq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i({cmd_i.id, cmd_i.len}),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign rd_id     = ram_rdata[ENTRY_W-1:LEN_BITS];
  assign rd_len    = ram_rdata[LEN_BITS-1:0];
  assign sum       = CMP_W'(total_q) + CMP_W'(rd_len);
  assign fit       = (sum <= CMP_W'(budget_i));
  assign slot_free = !out_valid_q || res_ready_i;
  assign count_dec = count_q - CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && slot_free && cmd_i.mode == MODE_SCHEDULE && count_q != '0) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_EVAL;
      BK_EVAL: begin
        if (slot_free) begin
          if (fit) begin
            state_d = (count_dec == '0) ? BK_FLUSH : BK_READ;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_FLUSH: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    total_d      = total_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    emit         = 1'b0;
    emit_res     = '0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o     = 1'b1;
          emit_res.last = 1'b1;
          if (cmd_i.mode == MODE_ENQUEUE) begin
            emit        = 1'b1;
            emit_res.id = cmd_i.id;
            if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              emit_res.status  = ST_FULL;
              emit_res.waiting = count_q;
            end else begin
              ram_we           = 1'b1;
              tail_d           = next_slot(tail_q);
              count_d          = count_q + CNT_W'(1);
              emit_res.status  = ST_ACCEPTED;
              emit_res.waiting = count_q + CNT_W'(1);
            end
          end else if (count_q == '0) begin
            emit            = 1'b1;
            emit_res.status = ST_EMPTY;
          end else begin
            total_d      = '0;
            n_d          = '0;
            pend_valid_d = 1'b0;
          end
        end
      end
      BK_READ: ram_re = 1'b1;
      BK_EVAL: begin
        if (slot_free) begin
          if (fit) begin
            head_d         = next_slot(head_q);
            count_d        = count_dec;
            total_d        = sum[BUDGET_W-1:0];
            n_d            = n_q + CNT_W'(1);
            pend_valid_d   = 1'b1;
            pend_d.status  = ST_STARTED;
            pend_d.id      = rd_id;
            pend_d.last    = 1'b0;
            pend_d.batch   = n_q + CNT_W'(1);
            pend_d.waiting = count_dec;
            emit           = pend_valid_q;
            emit_res       = pend_q;
          end else if (!pend_valid_q) begin
            head_d           = next_slot(head_q);
            count_d          = count_dec;
            emit             = 1'b1;
            emit_res.status  = ST_TOO_LONG;
            emit_res.id      = rd_id;
            emit_res.last    = 1'b1;
            emit_res.waiting = count_dec;
          end else begin
            emit          = 1'b1;
            emit_res      = pend_q;
            emit_res.last = 1'b1;
            pend_valid_d  = 1'b0;
          end
        end
      end
      BK_FLUSH: begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_res      = pend_q;
          emit_res.last = 1'b1;
          pend_valid_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d       = emit_res;
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    n_q     <= n_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
